### src/saq_pkg.sv
`timescale 1ns / 1ps
package saq_pkg;

  localparam int unsigned NORM_STEPS = 5;
  localparam int unsigned ROOT_BITS  = 32;
  localparam int unsigned HALF_BITS  = 17;
  localparam int unsigned QUO_BITS   = 15;

  localparam logic [1:0] KIND_GENERAL  = 2'd0;
  localparam logic [1:0] KIND_PARALLEL = 2'd1;
  localparam logic [1:0] KIND_ANTI     = 2'd2;

  localparam logic        REG_THRESH   = 1'b0;
  localparam logic [28:0] THRESH_RESET = 29'd268432771;

  localparam logic [14:0]        ONE_Q14 = 15'd16384;
  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [1:0]         case_taken;
  } out_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              nz;
    logic [2:0]        neg;
    logic [2:0][31:0]  mag;
    logic [63:0]       n;
    logic [33:0]       ts;
    logic [33:0]       tw;
    sqrt_st_t          rn;
    sqrt_st_t          rs;
    sqrt_st_t          rw;
    logic [14:0]       sv;
    logic [14:0]       wv;
    logic [2:0][46:0]  part;
    logic [2:0][14:0]  quo;
  } pipe_t;

  // one radix-4 digit of a restoring square root
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] dig);
    logic [35:0] r;
    logic [35:0] t;
    sqrt_st_t    o;
    r = {s.rem[33:0], dig};
    t = {2'b00, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### src/shortest_arc_quaternion_core.sv
`timescale 1ns / 1ps
// Shortest-arc rotation quaternion: takes two unit vectors in Q1.14 and returns the
// Q1.14 quaternion turning the first onto the second, with case_taken telling a
// general rotation, a parallel identity or an antiparallel half turn. One item enters
// per clock while the output buffer is not full or out_ready_i is high; each item runs
// through the 5-step length normalize, the 32-step square root of the axis length
// and the 15-step quotient chain that follows it. A two-entry output buffer keeps the
// pipeline moving while one result waits. parallel_threshold sits at byte address 0
// of the register port.
module shortest_arc_quaternion_core
  import saq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CH_LEN = NORM_STEPS + ROOT_BITS + 1 + QUO_BITS;
  localparam int unsigned LAT    = 4 + CH_LEN + 2;

  logic [28:0] thr_q;
  logic        en;
  logic [LAT-1:0] vld_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESH) ? {3'b000, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_THRESH) begin
      thr_q <= pwdata[28:0];
    end
  end

  // stage 1: products
  logic signed [31:0] p_q [9];
  logic signed [15:0] f1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= in_data_i.from_x * in_data_i.to_x;
      p_q[1] <= in_data_i.from_y * in_data_i.to_y;
      p_q[2] <= in_data_i.from_z * in_data_i.to_z;
      p_q[3] <= in_data_i.from_y * in_data_i.to_z;
      p_q[4] <= in_data_i.from_z * in_data_i.to_y;
      p_q[5] <= in_data_i.from_z * in_data_i.to_x;
      p_q[6] <= in_data_i.from_x * in_data_i.to_z;
      p_q[7] <= in_data_i.from_x * in_data_i.to_y;
      p_q[8] <= in_data_i.from_y * in_data_i.to_x;
      f1_q[0] <= in_data_i.from_x;
      f1_q[1] <= in_data_i.from_y;
      f1_q[2] <= in_data_i.from_z;
    end
  end

  // stage 2: dot and cross
  logic signed [33:0] d2_q;
  logic signed [32:0] c2_q [3];
  logic signed [15:0] f2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q    <= 34'(p_q[0]) + 34'(p_q[1]) + 34'(p_q[2]);
      c2_q[0] <= 33'(p_q[3]) - 33'(p_q[4]);
      c2_q[1] <= 33'(p_q[5]) - 33'(p_q[6]);
      c2_q[2] <= 33'(p_q[7]) - 33'(p_q[8]);
      f2_q    <= f1_q;
    end
  end

  // stage 3: classify, pick the vector, split sign and magnitude
  logic signed [33:0] thr_s;
  logic signed [33:0] tsd;
  logic signed [33:0] twd;
  logic [1:0]         kind3;
  logic signed [32:0] v3 [3];
  logic [1:0]         kind3_q;
  logic [2:0]         neg3_q;
  logic [31:0]        mag3_q [3];
  logic [33:0]        ts3_q;
  logic [33:0]        tw3_q;

  always_comb begin
    thr_s = $signed({5'b00000, thr_q});
    if (d2_q > thr_s) begin
      kind3 = KIND_PARALLEL;
    end else if (d2_q < -thr_s) begin
      kind3 = KIND_ANTI;
    end else begin
      kind3 = KIND_GENERAL;
    end
    if (kind3 == KIND_ANTI) begin
      if (f2_q[1] == '0 && f2_q[2] == '0) begin
        v3[0] = -33'(f2_q[2]);
        v3[1] = '0;
        v3[2] = 33'(f2_q[0]);
      end else begin
        v3[0] = '0;
        v3[1] = 33'(f2_q[2]);
        v3[2] = -33'(f2_q[1]);
      end
    end else begin
      v3 = c2_q;
    end
    tsd = ONE_Q28 - d2_q;
    twd = ONE_Q28 + d2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind3_q <= kind3;
      for (int i = 0; i < 3; i++) begin
        neg3_q[i] <= v3[i][32];
        mag3_q[i] <= v3[i][32] ? 32'(-v3[i]) : v3[i][31:0];
      end
      ts3_q <= tsd[33] ? '0 : {tsd[32:0], 1'b0};
      tw3_q <= twd[33] ? '0 : {twd[32:0], 1'b0};
    end
  end

  // stage 4: squares
  logic [63:0] sq4_q [3];
  logic [1:0]  kind4_q;
  logic [2:0]  neg4_q;
  logic [31:0] mag4_q [3];
  logic [33:0] ts4_q;
  logic [33:0] tw4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= mag3_q[i] * mag3_q[i];
      end
      kind4_q <= kind3_q;
      neg4_q  <= neg3_q;
      mag4_q  <= mag3_q;
      ts4_q   <= ts3_q;
      tw4_q   <= tw3_q;
    end
  end

  pipe_t head;
  pipe_t ch_d [CH_LEN];
  pipe_t ch_q [CH_LEN];

  always_comb begin
    head      = '0;
    head.kind = kind4_q;
    head.neg  = neg4_q;
    for (int i = 0; i < 3; i++) begin
      head.mag[i] = mag4_q[i];
    end
    head.n  = sq4_q[0] + sq4_q[1] + sq4_q[2];
    head.nz = (head.n != '0);
    head.ts = ts4_q;
    head.tw = tw4_q;
  end

  for (genvar j = 0; j < CH_LEN; j++) begin : g_ch
    pipe_t src;
    if (j == 0) begin : g_first
      assign src = head;
    end else begin : g_next
      assign src = ch_q[j-1];
    end

    if (j < NORM_STEPS) begin : g_norm
      localparam int unsigned SH = 16 >> j;
      always_comb begin
        ch_d[j] = src;
        if (src.n[63 -: (2 + 2*SH)] == '0) begin
          ch_d[j].n = src.n << (2*SH);
          for (int i = 0; i < 3; i++) begin
            ch_d[j].mag[i] = src.mag[i] << SH;
          end
        end
      end
    end else if (j < NORM_STEPS + ROOT_BITS) begin : g_sqrt
      localparam int unsigned K = j - NORM_STEPS;
      always_comb begin
        ch_d[j]    = src;
        ch_d[j].rn = sqrt_step(src.rn, src.n[63:62]);
        ch_d[j].n  = src.n << 2;
        if (K < HALF_BITS) begin
          ch_d[j].rs = sqrt_step(src.rs, src.ts[33:32]);
          ch_d[j].rw = sqrt_step(src.rw, src.tw[33:32]);
          ch_d[j].ts = src.ts << 2;
          ch_d[j].tw = src.tw << 2;
        end
      end
    end else if (j == NORM_STEPS + ROOT_BITS) begin : g_prep
      logic [17:0] hs;
      logic [17:0] hw;
      always_comb begin
        ch_d[j] = src;
        hs = {1'b0, src.rs.root[16:0]} + 18'd1;
        hw = {1'b0, src.rw.root[16:0]} + 18'd1;
        ch_d[j].sv = (hs[17:1] > 17'(ONE_Q14)) ? ONE_Q14 : hs[15:1];
        ch_d[j].wv = (hw[17:1] > 17'(ONE_Q14)) ? ONE_Q14 : hw[15:1];
        for (int i = 0; i < 3; i++) begin
          ch_d[j].part[i] = {1'b0, src.mag[i], 14'b0} + 47'(src.rn.root >> 1);
          ch_d[j].quo[i]  = '0;
        end
      end
    end else begin : g_div
      localparam int unsigned B = QUO_BITS - 1 - (j - NORM_STEPS - ROOT_BITS - 1);
      logic [46:0] dv;
      always_comb begin
        ch_d[j] = src;
        dv = {15'b0, src.rn.root} << B;
        for (int i = 0; i < 3; i++) begin
          if (src.part[i] >= dv) begin
            ch_d[j].part[i]   = src.part[i] - dv;
            ch_d[j].quo[i][B] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < CH_LEN; j++) begin
        ch_q[j] <= ch_d[j];
      end
    end
  end

  // scale by the half-angle sine
  pipe_t       tail;
  logic [14:0] qs [3];
  logic [14:0] mul_b;
  logic [1:0]  kind_m_q;
  logic        nz_m_q;
  logic [2:0]  neg_m_q;
  logic [14:0] w_m_q;
  logic [29:0] prod_m_q [3];

  assign tail = ch_q[CH_LEN-1];

  always_comb begin
    mul_b = (tail.kind == KIND_ANTI) ? ONE_Q14 : tail.sv;
    for (int i = 0; i < 3; i++) begin
      qs[i] = (tail.quo[i] > ONE_Q14) ? ONE_Q14 : tail.quo[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_m_q <= tail.kind;
      nz_m_q   <= tail.nz;
      neg_m_q  <= tail.neg;
      w_m_q    <= tail.wv;
      for (int i = 0; i < 3; i++) begin
        prod_m_q[i] <= qs[i] * mul_b;
      end
    end
  end

  // round, saturate, assemble
  logic [30:0]        rsum [3];
  logic [14:0]        cm [3];
  logic signed [15:0] cv [3];
  out_t               res;
  out_t               oreg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = {1'b0, prod_m_q[i]} + 31'd8192;
      cm[i]   = (rsum[i][30:14] > 17'(ONE_Q14)) ? ONE_Q14 : rsum[i][28:14];
      if (!nz_m_q) begin
        cm[i] = '0;
      end
      cv[i] = neg_m_q[i] ? -16'(cm[i]) : 16'(cm[i]);
    end
    res.case_taken = kind_m_q;
    case (kind_m_q)
      KIND_PARALLEL: begin
        res.quat_w = 16'(ONE_Q14);
        res.quat_x = '0;
        res.quat_y = '0;
        res.quat_z = '0;
      end
      KIND_ANTI: begin
        res.quat_w = '0;
        res.quat_x = cv[0];
        res.quat_y = cv[1];
        res.quat_z = cv[2];
      end
      default: begin
        res.quat_w = 16'(w_m_q);
        res.quat_x = cv[0];
        res.quat_y = cv[1];
        res.quat_z = cv[2];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oreg_q <= res;
    end
  end

  // output buffer
  logic [1:0] cnt_q, cnt_d;
  out_t       head_q, head_d;
  out_t       spare_q, spare_d;
  logic       push, pop;

  assign en          = (cnt_q != 2'd2) || out_ready_i;
  assign in_ready_o  = en;
  assign push        = en && vld_q[LAT-1];
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = head_q;

  always_comb begin
    head_d  = head_q;
    spare_d = spare_q;
    cnt_d   = cnt_q + 2'(push) - 2'(pop);
    if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
      if (push) begin
        head_d = oreg_q;
      end
    end else if (cnt_q == 2'd1) begin
      if (push) begin
        spare_d = oreg_q;
      end
    end else if (pop) begin
      head_d = spare_q;
      if (push) begin
        spare_d = oreg_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output buffer overflow");

  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.case_taken == KIND_PARALLEL |->
      out_data_o.quat_w == 16'sd16384 && out_data_o.quat_x == '0 &&
      out_data_o.quat_y == '0 && out_data_o.quat_z == '0)
    else $error("parallel item not identity");

  a_anti: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.case_taken == KIND_ANTI |-> out_data_o.quat_w == '0)
    else $error("half turn with nonzero w");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.quat_w >= -16'sd16384 && out_data_o.quat_w <= 16'sd16384 &&
      out_data_o.case_taken != 2'd3)
    else $error("result out of range");

endmodule
